// ----- src/msd_pkg.sv -----
// ---------------------------------------------------------------------------
// msd_pkg: shared types and constants
// Widths, controller states and the command/status bundles used between the
// controller and the datapath of the mean and deviation block.
// ---------------------------------------------------------------------------
package msd_pkg;

  // Word field widths
  localparam int SampleW = 24;
  localparam int SumW    = 32;
  localparam int SqW     = 56;
  localparam int CountW  = 9;
  localparam int ResW    = 32;

  // Final arithmetic widths
  localparam int ProdW   = 64;   // n*Q, S*S and their difference
  localparam int MW      = 16;   // n*(n-1)
  localparam int DivW    = 80;   // dividend (d << 16)
  localparam int DivSteps = 80;
  localparam int DivCntW = 7;
  localparam int RadW    = 64;
  localparam int RootW   = 32;
  localparam int RemW    = 34;
  localparam int SqrtSteps = 32;
  localparam int SqrtCntW = 5;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_PRODUCTS,
    ST_DIFF,
    ST_MEAN_WAIT,
    ST_VAR_WAIT,
    ST_ROOT_WAIT
  } msd_state_t;

  // Controller to datapath
  typedef struct packed {
    logic accumulate;
    logic load_products;
    logic load_diff;
    logic div_start;
    logic div_sel_var;
    logic take_mean;
    logic sqrt_start;
    logic emit;
  } msd_cmd_t;

  // Datapath to controller
  typedef struct packed {
    logic div_done;
    logic sqrt_done;
  } msd_status_t;

endpackage

// ----- src/msd_div.sv -----
// ---------------------------------------------------------------------------
// msd_div: restoring divider
// Unsigned DivW-bit by MW-bit division, one quotient bit per cycle. The
// quotient is final in the cycle that done is high and holds until the next
// start.
// ---------------------------------------------------------------------------
module msd_div (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        start,
  input  logic [msd_pkg::DivW-1:0]    dividend,
  input  logic [msd_pkg::MW-1:0]      divisor,
  output logic [msd_pkg::DivW-1:0]    quotient,
  output logic                        done
);
  import msd_pkg::*;

  logic [DivW-1:0]    quo_r;
  logic [MW-1:0]      rem_r;
  logic [MW-1:0]      divisor_r;
  logic [DivCntW-1:0] cnt_r;
  logic               run_r;
  logic               done_r;

  logic [MW:0]        shifted;
  logic [MW:0]        diff;
  logic               ge;
  logic [MW-1:0]      rem_nxt;

  // Shift in one dividend bit and try the subtraction
  always_comb begin
    shifted = {rem_r, quo_r[DivW-1]};
    diff    = shifted - {1'b0, divisor_r};
    ge      = (shifted >= {1'b0, divisor_r});
    rem_nxt = ge ? diff[MW-1:0] : shifted[MW-1:0];
  end

  // Control of the iteration
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      run_r  <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      done_r <= 1'b0;
      if (start) begin
        run_r <= 1'b1;
        cnt_r <= '0;
      end else if (run_r) begin
        cnt_r <= cnt_r + 1'b1;
        if (cnt_r == DivCntW'(DivSteps - 1)) begin
          run_r  <= 1'b0;
          done_r <= 1'b1;
        end
      end
    end
  end

  // Quotient bits enter at the bottom as dividend bits leave the top
  always_ff @(posedge clk) begin
    if (start) begin
      quo_r     <= dividend;
      rem_r     <= '0;
      divisor_r <= divisor;
    end else if (run_r) begin
      quo_r <= {quo_r[DivW-2:0], ge};
      rem_r <= rem_nxt;
    end
  end

  assign quotient = quo_r;
  assign done     = done_r;

endmodule

// ----- src/msd_sqrt.sv -----
// ---------------------------------------------------------------------------
// msd_sqrt: integer square root
// Digit-by-digit floor square root of a RadW-bit value, two radicand bits per
// cycle. The root is final in the cycle that done is high.
// ---------------------------------------------------------------------------
module msd_sqrt (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        start,
  input  logic [msd_pkg::RadW-1:0]    radicand,
  output logic [msd_pkg::RootW-1:0]   root,
  output logic                        done
);
  import msd_pkg::*;

  logic [RadW-1:0]     rad_r;
  logic [RemW-1:0]     rem_r;
  logic [RootW-1:0]    root_r;
  logic [SqrtCntW-1:0] cnt_r;
  logic                run_r;
  logic                done_r;

  logic [RemW+1:0]     rem_sh;
  logic [RemW+1:0]     trial;
  logic [RemW+1:0]     diff;
  logic                ge;
  logic [RemW-1:0]     rem_nxt;
  logic [RootW-1:0]    root_nxt;

  // Bring down two bits, test 4*root+1
  always_comb begin
    rem_sh   = {rem_r, rad_r[RadW-1:RadW-2]};
    trial    = {2'b00, root_r, 2'b01};
    diff     = rem_sh - trial;
    ge       = (rem_sh >= trial);
    rem_nxt  = ge ? diff[RemW-1:0] : rem_sh[RemW-1:0];
    root_nxt = {root_r[RootW-2:0], ge};
  end

  // Iteration control
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      run_r  <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      done_r <= 1'b0;
      if (start) begin
        run_r <= 1'b1;
        cnt_r <= '0;
      end else if (run_r) begin
        cnt_r <= cnt_r + 1'b1;
        if (cnt_r == SqrtCntW'(SqrtSteps - 1)) begin
          run_r  <= 1'b0;
          done_r <= 1'b1;
        end
      end
    end
  end

  // Remainder and partial root
  always_ff @(posedge clk) begin
    if (start) begin
      rad_r  <= radicand;
      rem_r  <= '0;
      root_r <= '0;
    end else if (run_r) begin
      rad_r  <= {rad_r[RadW-3:0], 2'b00};
      rem_r  <= rem_nxt;
      root_r <= root_nxt;
    end
  end

  assign root = root_r;
  assign done = done_r;

endmodule

// ----- src/msd_datapath.sv -----
// ---------------------------------------------------------------------------
// msd_datapath: accumulators and final arithmetic
// Keeps count, sum and sum of squares of the run, then forms n*Q - S*S and
// n*(n-1), divides for the mean and the variance and takes the root.
// ---------------------------------------------------------------------------
module msd_datapath #(
  parameter int MAX_SAMPLES = 256,
  parameter int SAMPLE_BITS = 24
) (
  input  logic                         clk,
  input  logic                         rst_n,
  input  msd_pkg::msd_cmd_t            cmd,
  output msd_pkg::msd_status_t         status,
  input  logic [msd_pkg::SampleW-1:0]  in_sample,
  output logic                         out_strobe,
  output logic [msd_pkg::ResW-1:0]     out_mean_q8,
  output logic [msd_pkg::ResW-1:0]     out_deviation_q8,
  output logic                         out_deviation_valid,
  output logic [msd_pkg::CountW-1:0]   out_sample_count,
  output logic                         out_overflowed
);
  import msd_pkg::*;

  localparam logic [SampleW-1:0] SampleMask =
    SampleW'((SampleW+1)'(1) << SAMPLE_BITS) - SampleW'(1);
  localparam logic [CountW-1:0] Capacity = CountW'(MAX_SAMPLES);

  // Accumulators
  logic [CountW-1:0] count_r;
  logic [SumW-1:0]   sum_r;
  logic [SqW-1:0]    sq_r;
  logic              dropped_r;

  // Final arithmetic
  logic [ProdW-1:0]  nq_r;
  logic [ProdW-1:0]  ss_r;
  logic [MW-1:0]     m_r;
  logic [ProdW-1:0]  d_r;
  logic [ResW-1:0]   mean_r;

  // Output word
  logic              strobe_r;
  logic [ResW-1:0]   mean_out_r;
  logic [ResW-1:0]   dev_out_r;
  logic              valid_out_r;
  logic [CountW-1:0] count_out_r;
  logic              ovf_out_r;

  logic [SampleW-1:0]   x;
  logic [2*SampleW-1:0] x_sq;
  logic                 has_room;
  logic                 two_plus;
  logic [DivW-1:0]      div_dividend;
  logic [MW-1:0]        div_divisor;
  logic [DivW-1:0]      quotient;
  logic [RootW-1:0]     root;
  logic                 div_done;
  logic                 sqrt_done;

  // Sample square for the running sum of squares
  always_comb begin
    x        = in_sample & SampleMask;
    x_sq     = x * x;
    has_room = (count_r < Capacity);
    two_plus = (count_r >= CountW'(2));
  end

  // Accumulate while there is room, clear once the result goes out
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      count_r   <= '0;
      sum_r     <= '0;
      sq_r      <= '0;
      dropped_r <= 1'b0;
    end else if (cmd.emit) begin
      count_r   <= '0;
      sum_r     <= '0;
      sq_r      <= '0;
      dropped_r <= 1'b0;
    end else if (cmd.accumulate) begin
      if (has_room) begin
        count_r <= count_r + 1'b1;
        sum_r   <= sum_r + SumW'(x);
        sq_r    <= sq_r + SqW'(x_sq);
      end else begin
        dropped_r <= 1'b1;
      end
    end
  end

  // n*Q, S*S and n*(n-1), then their difference
  always_ff @(posedge clk) begin
    if (cmd.load_products) begin
      nq_r <= ProdW'(count_r) * ProdW'(sq_r);
      ss_r <= ProdW'(sum_r) * ProdW'(sum_r);
      m_r  <= MW'(count_r) * (MW'(count_r) - MW'(1));
    end
    if (cmd.load_diff) begin
      d_r <= (nq_r >= ss_r) ? (nq_r - ss_r) : '0;
    end
    if (cmd.take_mean) begin
      mean_r <= quotient[ResW-1:0];
    end
  end

  // Divider operands: mean is (S << 8) / n, variance is (d << 16) / m
  always_comb begin
    if (cmd.div_sel_var) begin
      div_dividend = {d_r, 16'h0000};
      div_divisor  = m_r;
    end else begin
      div_dividend = DivW'({sum_r, 8'h00});
      div_divisor  = MW'(count_r);
    end
  end

  msd_div u_div (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (cmd.div_start),
    .dividend (div_dividend),
    .divisor  (div_divisor),
    .quotient (quotient),
    .done     (div_done)
  );

  msd_sqrt u_sqrt (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (cmd.sqrt_start),
    .radicand (quotient[RadW-1:0]),
    .root     (root),
    .done     (sqrt_done)
  );

  assign status.div_done  = div_done;
  assign status.sqrt_done = sqrt_done;

  // Result strobe
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      strobe_r <= 1'b0;
    end else begin
      strobe_r <= cmd.emit;
    end
  end

  // Result word; a single sample gives no deviation
  always_ff @(posedge clk) begin
    if (cmd.emit) begin
      mean_out_r  <= mean_r;
      dev_out_r   <= two_plus ? root : '0;
      valid_out_r <= two_plus;
      count_out_r <= count_r;
      ovf_out_r   <= dropped_r;
    end
  end

  assign out_strobe          = strobe_r;
  assign out_mean_q8         = mean_out_r;
  assign out_deviation_q8    = dev_out_r;
  assign out_deviation_valid = valid_out_r;
  assign out_sample_count    = count_out_r;
  assign out_overflowed      = ovf_out_r;

endmodule

// ----- src/msd_ctrl.sv -----
// ---------------------------------------------------------------------------
// msd_ctrl: sequencing controller
// Accepts samples while idle and, after the last one, steps the datapath
// through products, difference, two divisions and the square root.
// ---------------------------------------------------------------------------
module msd_ctrl (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  start,
  input  logic                  in_last,
  output logic                  busy,
  output msd_pkg::msd_cmd_t     cmd,
  input  msd_pkg::msd_status_t  status
);
  import msd_pkg::*;

  msd_state_t state_r;
  msd_state_t state_nxt;
  logic       accept;

  assign accept = start && (state_r == ST_IDLE);

  // State register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  // Next state
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      ST_IDLE: begin
        if (accept && in_last) state_nxt = ST_PRODUCTS;
      end
      ST_PRODUCTS: state_nxt = ST_DIFF;
      ST_DIFF:     state_nxt = ST_MEAN_WAIT;
      ST_MEAN_WAIT: begin
        if (status.div_done) state_nxt = ST_VAR_WAIT;
      end
      ST_VAR_WAIT: begin
        if (status.div_done) state_nxt = ST_ROOT_WAIT;
      end
      ST_ROOT_WAIT: begin
        if (status.sqrt_done) state_nxt = ST_IDLE;
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  // Commands
  always_comb begin
    cmd  = '0;
    busy = 1'b1;
    case (state_r)
      ST_IDLE: begin
        busy           = 1'b0;
        cmd.accumulate = accept;
      end
      ST_PRODUCTS: cmd.load_products = 1'b1;
      ST_DIFF: begin
        cmd.load_diff = 1'b1;
        cmd.div_start = 1'b1;
      end
      ST_MEAN_WAIT: begin
        if (status.div_done) begin
          cmd.take_mean   = 1'b1;
          cmd.div_start   = 1'b1;
          cmd.div_sel_var = 1'b1;
        end
      end
      ST_VAR_WAIT: begin
        cmd.div_sel_var = 1'b1;
        cmd.sqrt_start  = status.div_done;
      end
      ST_ROOT_WAIT: cmd.emit = status.sqrt_done;
      default: cmd = '0;
    endcase
  end

endmodule

// ----- src/mean_and_sample_std_dev.sv -----
// ---------------------------------------------------------------------------
// mean_and_sample_std_dev: mean and corrected sample standard deviation
// A run of unsigned samples goes in one word per cycle while busy is low,
// the last one flagged by in_last. A sample is taken at a clock edge where
// start is high and busy is low. Up to MAX_SAMPLES samples are accumulated;
// later ones are dropped and flagged in out_overflowed.
// After the last sample busy stays high through products and difference, two
// passes of the bit-serial divider (80 steps and then done each, mean then
// variance) and the two-bit-per-cycle square root (32 steps and then done).
// out_strobe is high for one cycle, the first cycle with busy low again, with
// the mean and deviation in Q24.8, the count and the flags; the receiver
// cannot hold it off. A new run may start in the cycle busy falls. Within a
// run samples enter at one per cycle while start is high.
// Reset (rst_n low at a clock edge) clears the accumulators and returns the
// block to idle; no result is pending afterwards.
// ---------------------------------------------------------------------------
module mean_and_sample_std_dev #(
  parameter int MAX_SAMPLES = 256,
  parameter int SAMPLE_BITS = 24
) (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic                         start,
  output logic                         busy,
  input  logic [msd_pkg::SampleW-1:0]  in_sample,
  input  logic                         in_last,
  output logic                         out_strobe,
  output logic [msd_pkg::ResW-1:0]     out_mean_q8,
  output logic [msd_pkg::ResW-1:0]     out_deviation_q8,
  output logic                         out_deviation_valid,
  output logic [msd_pkg::CountW-1:0]   out_sample_count,
  output logic                         out_overflowed
);
  import msd_pkg::*;

  msd_cmd_t    cmd;
  msd_status_t status;

  msd_ctrl u_ctrl (
    .clk     (clk),
    .rst_n   (rst_n),
    .start   (start),
    .in_last (in_last),
    .busy    (busy),
    .cmd     (cmd),
    .status  (status)
  );

  msd_datapath #(
    .MAX_SAMPLES (MAX_SAMPLES),
    .SAMPLE_BITS (SAMPLE_BITS)
  ) u_datapath (
    .clk                 (clk),
    .rst_n               (rst_n),
    .cmd                 (cmd),
    .status              (status),
    .in_sample           (in_sample),
    .out_strobe          (out_strobe),
    .out_mean_q8         (out_mean_q8),
    .out_deviation_q8    (out_deviation_q8),
    .out_deviation_valid (out_deviation_valid),
    .out_sample_count    (out_sample_count),
    .out_overflowed      (out_overflowed)
  );

endmodule

// ----- verif/mean_and_sample_std_dev_checker.sv -----
`timescale 1ns / 100ps
// ---------------------------------------------------------------------------
// mean_and_sample_std_dev_checker: result predictor and comparator
// Watches the sample and result ports of the mean/deviation block. Every
// accepted word updates a private copy of the run accumulators, and every word
// flagged last queues the expected statistics. Each result strobe is compared
// field by field with the oldest queued entry.
// ---------------------------------------------------------------------------
module mean_and_sample_std_dev_checker #(
  parameter int MAX_SAMPLES = 256,
  parameter int SAMPLE_BITS = 24
) (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic                         start,
  input  logic                         busy,
  input  logic [msd_pkg::SampleW-1:0]  in_sample,
  input  logic                         in_last,
  input  logic                         out_strobe,
  input  logic [msd_pkg::ResW-1:0]     out_mean_q8,
  input  logic [msd_pkg::ResW-1:0]     out_deviation_q8,
  input  logic                         out_deviation_valid,
  input  logic [msd_pkg::CountW-1:0]   out_sample_count,
  input  logic                         out_overflowed,
  output int                           fail_count,
  output int                           pending
);

  typedef struct {
    logic [msd_pkg::ResW-1:0]   mean_q8;
    logic [msd_pkg::ResW-1:0]   deviation_q8;
    logic                       deviation_valid;
    logic [msd_pkg::CountW-1:0] sample_count;
    logic                       overflowed;
  } run_stats_t;

  // Run accumulators, cleared after every last word
  logic [msd_pkg::CountW-1:0] acc_count;
  logic [msd_pkg::SumW-1:0]   acc_sum;
  logic [msd_pkg::SqW-1:0]    acc_sq;
  logic                       acc_dropped;

  run_stats_t expected_stats[$];

  initial begin
    fail_count  = 0;
    pending     = 0;
    acc_count   = '0;
    acc_sum     = '0;
    acc_sq      = '0;
    acc_dropped = 1'b0;
  end

  // Floor of the square root, built one root bit at a time from the top
  function automatic bit [31:0] root_floor(input bit [63:0] v);
    bit [31:0] r;
    bit [31:0] c;
    r = '0;
    for (int b = 31; b >= 0; b--) begin
      c = r | (32'd1 << b);
      if (64'(c) * 64'(c) <= v) r = c;
    end
    return r;
  endfunction

  // Fold one word into the run; on the last word queue the statistics
  function automatic void take_sample(input logic [msd_pkg::SampleW-1:0] smp,
                                      input logic lst);
    bit [63:0]  x;
    bit [63:0]  n;
    bit [63:0]  s;
    bit [63:0]  q;
    bit [63:0]  nq;
    bit [63:0]  ss;
    bit [63:0]  d;
    bit [63:0]  m;
    bit [63:0]  v;
    run_stats_t st;
    x = 64'(smp) & ((64'd1 << SAMPLE_BITS) - 64'd1);
    if (acc_count < MAX_SAMPLES) begin
      acc_count = acc_count + 1'b1;
      acc_sum   = acc_sum + x[msd_pkg::SumW-1:0];
      acc_sq    = acc_sq + msd_pkg::SqW'(x * x);
    end else begin
      acc_dropped = 1'b1;
    end
    if (!lst) return;

    n = 64'(acc_count);
    s = 64'(acc_sum);
    q = 64'(acc_sq);
    st.mean_q8         = '0;
    st.deviation_q8    = '0;
    st.deviation_valid = 1'b0;
    if (n != 0) st.mean_q8 = msd_pkg::ResW'((s << 8) / n);
    // Variance scaled by 2^16, wrapped to 64 bits like the datapath
    if (n >= 2) begin
      nq = n * q;
      ss = s * s;
      d  = (nq >= ss) ? nq - ss : 64'd0;
      m  = n * (n - 1);
      v  = (d / m) * 64'd65536 + ((d % m) * 64'd65536) / m;
      st.deviation_q8    = root_floor(v);
      st.deviation_valid = 1'b1;
    end
    st.sample_count = acc_count;
    st.overflowed   = acc_dropped;
    expected_stats.push_back(st);

    acc_count   = '0;
    acc_sum     = '0;
    acc_sq      = '0;
    acc_dropped = 1'b0;
  endfunction

  function automatic void check_field(input string name, input longint unsigned exp_v,
                                      input longint unsigned act_v);
    if (exp_v !== act_v) begin
      $display("%0t: %s mismatch: expected %0d actual %0d", $time, name, exp_v, act_v);
      fail_count++;
    end
  endfunction

  always @(posedge clk) begin
    run_stats_t st;
    if (!rst_n) begin
      acc_count   = '0;
      acc_sum     = '0;
      acc_sq      = '0;
      acc_dropped = 1'b0;
      expected_stats.delete();
    end else begin
      // Result side first; a word accepted at this edge cannot be its cause
      if (out_strobe) begin
        if (expected_stats.size() == 0) begin
          $display("%0t: result with none expected: mean %0d dev %0d count %0d",
                   $time, out_mean_q8, out_deviation_q8, out_sample_count);
          fail_count++;
        end else begin
          st = expected_stats.pop_front();
          check_field("mean_q8", st.mean_q8, out_mean_q8);
          check_field("deviation_q8", st.deviation_q8, out_deviation_q8);
          check_field("deviation_valid", st.deviation_valid, out_deviation_valid);
          check_field("sample_count", st.sample_count, out_sample_count);
          check_field("overflowed", st.overflowed, out_overflowed);
        end
      end
      if (start && !busy) take_sample(in_sample, in_last);
    end
    pending = expected_stats.size();
  end

endmodule

// ----- verif/mean_and_sample_std_dev_tb.sv -----
`timescale 1ns / 100ps
// ---------------------------------------------------------------------------
// mean_and_sample_std_dev_tb: testbench top for the mean/deviation block
// Drives runs of sample words, short directed runs first and then random
// runs of mixed length and content, including runs past capacity. Sender
// gaps vary by phase. The checker beside the block predicts and compares.
// ---------------------------------------------------------------------------
module mean_and_sample_std_dev_tb;

  localparam int MaxSamples = 256;
  localparam int SampleBits = 24;
  localparam int PhaseWords = 650;

  // Content styles for a random run
  typedef enum int { VAL_ANY, VAL_SMALL, VAL_HIGH, VAL_FLAT } val_kind_t;

  logic                         clk;
  logic                         rst_n;
  logic                         start;
  logic                         busy;
  logic [msd_pkg::SampleW-1:0]  in_sample;
  logic                         in_last;
  logic                         out_strobe;
  logic [msd_pkg::ResW-1:0]     out_mean_q8;
  logic [msd_pkg::ResW-1:0]     out_deviation_q8;
  logic                         out_deviation_valid;
  logic [msd_pkg::CountW-1:0]   out_sample_count;
  logic                         out_overflowed;
  int                           fail_count;
  int                           pending;

  int idle_pct;
  int words_sent;

  mean_and_sample_std_dev #(
    .MAX_SAMPLES(MaxSamples),
    .SAMPLE_BITS(SampleBits)
  ) uut (
    .clk                (clk),
    .rst_n              (rst_n),
    .start              (start),
    .busy               (busy),
    .in_sample          (in_sample),
    .in_last            (in_last),
    .out_strobe         (out_strobe),
    .out_mean_q8        (out_mean_q8),
    .out_deviation_q8   (out_deviation_q8),
    .out_deviation_valid(out_deviation_valid),
    .out_sample_count   (out_sample_count),
    .out_overflowed     (out_overflowed)
  );

  mean_and_sample_std_dev_checker #(
    .MAX_SAMPLES(MaxSamples),
    .SAMPLE_BITS(SampleBits)
  ) checker_i (
    .clk                (clk),
    .rst_n              (rst_n),
    .start              (start),
    .busy               (busy),
    .in_sample          (in_sample),
    .in_last            (in_last),
    .out_strobe         (out_strobe),
    .out_mean_q8        (out_mean_q8),
    .out_deviation_q8   (out_deviation_q8),
    .out_deviation_valid(out_deviation_valid),
    .out_sample_count   (out_sample_count),
    .out_overflowed     (out_overflowed),
    .fail_count         (fail_count),
    .pending            (pending)
  );

  initial clk = 1'b0;
  always #1 clk = ~clk;

  // Hard stop if the run hangs
  initial begin
    #5000000;
    $display("mean_and_sample_std_dev_tb NOT OK");
    $finish;
  end

  // Offer one word at a falling edge and hold it until an edge with busy low
  task automatic send_word(input logic [msd_pkg::SampleW-1:0] smp, input logic lst);
    logic busy_now;
    while ($urandom_range(99, 0) < idle_pct) begin
      start <= 1'b0;
      @(negedge clk);
    end
    start     <= 1'b1;
    in_sample <= smp;
    in_last   <= lst;
    do begin
      busy_now = busy;
      @(posedge clk);
    end while (busy_now);
    words_sent++;
    @(negedge clk);
  endtask

  function automatic logic [msd_pkg::SampleW-1:0] pick_sample(
      input val_kind_t kind, input logic [msd_pkg::SampleW-1:0] base);
    case (kind)
      VAL_SMALL: return msd_pkg::SampleW'($urandom_range(255, 0));
      VAL_HIGH:  return {msd_pkg::SampleW{1'b1}} - msd_pkg::SampleW'($urandom_range(15, 0));
      VAL_FLAT:  return base;
      default:   return msd_pkg::SampleW'($urandom);
    endcase
  endfunction

  task automatic send_run(input int len, input val_kind_t kind);
    logic [msd_pkg::SampleW-1:0] base;
    base = msd_pkg::SampleW'($urandom);
    for (int i = 0; i < len; i++) send_word(pick_sample(kind, base), i == len - 1);
  endtask

  // Mostly short runs, some medium, a few near or past capacity
  task automatic random_runs(input int word_target);
    int        r;
    int        len;
    val_kind_t kind;
    while (words_sent < word_target) begin
      r = $urandom_range(99, 0);
      if (r < 80) len = $urandom_range(12, 1);
      else if (r < 95) len = $urandom_range(64, 13);
      else len = $urandom_range(MaxSamples + 6, MaxSamples - 6);
      kind = val_kind_t'($urandom_range(3, 0));
      send_run(len, kind);
    end
  endtask

  initial begin
    rst_n     = 1'b0;
    start     = 1'b0;
    in_sample = '0;
    in_last   = 1'b0;
    idle_pct  = 21;
    words_sent = 0;
    repeat (12) @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    // Directed: single-word runs at both extremes
    send_word('0, 1'b1);
    send_word({msd_pkg::SampleW{1'b1}}, 1'b1);
    // widest spread, then equal words (zero deviation)
    send_word('0, 1'b0);
    send_word({msd_pkg::SampleW{1'b1}}, 1'b1);
    send_word({msd_pkg::SampleW{1'b1}}, 1'b0);
    send_word({msd_pkg::SampleW{1'b1}}, 1'b1);
    // small ramp with a fractional mean
    send_word(24'd1, 1'b0);
    send_word(24'd2, 1'b0);
    send_word(24'd3, 1'b0);
    send_word(24'd4, 1'b1);
    // alternating bit patterns
    send_word(24'hAAAAAA, 1'b0);
    send_word(24'h555555, 1'b1);
    // flat run
    for (int i = 0; i < 5; i++) send_word(24'd7, i == 4);

    // Run past capacity: dropped words, last flag on a dropped word
    send_run(MaxSamples + 1, VAL_HIGH);

    random_runs(PhaseWords);
    idle_pct = 76;
    random_runs(2 * PhaseWords);
    idle_pct = 0;
    random_runs(3 * PhaseWords);
    start <= 1'b0;

    // Drain: all results back, then allow the full compute latency
    while (pending != 0) @(negedge clk);
    repeat (250) @(negedge clk);
    if (fail_count == 0) begin
      $display("mean_and_sample_std_dev_tb OK");
    end else begin
      $display("mean_and_sample_std_dev_tb NOT OK");
    end
    $finish;
  end

endmodule

// ----- mean_and_sample_std_dev.f -----
src/msd_pkg.sv
src/msd_div.sv
src/msd_sqrt.sv
src/msd_datapath.sv
src/msd_ctrl.sv
src/mean_and_sample_std_dev.sv
verif/mean_and_sample_std_dev_checker.sv
verif/mean_and_sample_std_dev_tb.sv
